// File: rtl/core/cat_pkg.sv
// shared types and constants for the comment aware tokenizer
// no dependencies; imported by the interfaces, the token ram and the top level
package cat_pkg;

	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int LINE_W = 24;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_HIGH  = 8'h80;

	typedef enum logic [2:0] {
		MODE_SKIP,
		MODE_SLASH,
		MODE_LINE,
		MODE_BLOCK,
		MODE_QUOTE,
		MODE_WORD
	} scan_mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_CHAR,
		KIND_EMPTY,
		KIND_EOL,
		KIND_EOF
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EOL,
		ST_PRIME,
		ST_TOK,
		ST_EMPTY,
		ST_EOF
	} seq_state_t;

	// control bytes, space and the upper half count as blanks
	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c <= CH_SPACE) || (c >= CH_HIGH);
	endfunction

endpackage

// File: rtl/core/cat_ifs.sv
// valid/ready channel interfaces for the text bytes and the token results
// depends on cat_pkg for the payload widths
interface cat_text_if;
	import cat_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink (input valid, input in_char, output ready);
endinterface

interface cat_token_if;
	import cat_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] tok_char;
	logic              tok_last;
	logic [LINE_W-1:0] line_number;

	modport source (output valid, output kind, output tok_char, output tok_last,
		output line_number, input ready);
	modport sink (input valid, input kind, input tok_char, input tok_last,
		input line_number, output ready);
endinterface

// File: rtl/core/comment_aware_tokenizer.sv
// comment aware tokenizer top level; uses cat_pkg, cat_ifs and cat_tok_ram
//
// text takes one byte per transaction, byte 0 ends the input. whitespace,
// line comments and block comments between tokens are dropped; quoted
// strings and bare words go to a token ram and leave on token one character
// per transaction with tok_last on the final one. empty tokens, end of line
// (allow_newlines 0) and end of input are single transactions of their own.
// a byte that yields no result leaves the sequencer idle, so such runs stream
// at one byte per cycle. a byte that yields results holds text.ready low until
// its last result is loaded into the output register; a token first reads
// ram entry 0 and then keeps the ram read one character ahead of the output.
// token stalls freeze the sequencer; the output register keeps the pending
// result and the next byte is taken as soon as the sequencer is idle.
// reset clears the scanner, line counter and output valid; allow_newlines
// comes up as 1. the token ram needs no clearing, it is written before read.
module comment_aware_tokenizer #(
	parameter int TOKEN_MAX = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	cat_text_if.sink      text,
	cat_token_if.source   token,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data
);
	import cat_pkg::*;

	localparam int IDX_W = $clog2(TOKEN_MAX);
	localparam int LEN_W = $clog2(TOKEN_MAX + 1);

	// scanner state
	scan_mode_t        mode_q, mode_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic              nl_q, nl_d;
	logic              star_q, star_d;
	logic [LINE_W-1:0] line_q, line_d, line_inc;
	logic              allow_q;

	// scanner step outputs
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [CHAR_W-1:0] wr_data;
	logic              f_eol, f_emit, f_eof, run_skip, nl_mid;
	logic [LEN_W-1:0]  emit_len;
	logic [CHAR_W-1:0] c;
	logic              in_acc;

	// result sequencer
	seq_state_t        state_q, state_d;
	logic              eof_q;
	logic [IDX_W-1:0]  emit_last_q;
	logic [IDX_W-1:0]  idx_q, rd_addr;
	logic [CHAR_W-1:0] rd_data_q;
	logic [LINE_W-1:0] res_line_q;
	logic              gen_valid, gen_last, adv, out_load, tok_last_hit;
	kind_t             gen_kind;
	logic [CHAR_W-1:0] gen_char;

	// output register
	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;
	logic [LINE_W-1:0] out_line_q;

	assign c      = text.in_char;
	assign in_acc = text.valid && text.ready;
	assign text.ready = (state_q == ST_IDLE);

	assign line_inc = (line_q == {LINE_W{1'b1}}) ? line_q : line_q + LINE_W'(1);

	// one scanner step for the byte on text
	always_comb begin
		mode_d   = mode_q;
		len_d    = len_q;
		nl_d     = nl_q;
		star_d   = star_q;
		line_d   = line_q;
		wr_en    = 1'b0;
		wr_addr  = len_q[IDX_W-1:0];
		wr_data  = c;
		f_eol    = 1'b0;
		f_emit   = 1'b0;
		f_eof    = 1'b0;
		emit_len = len_q;
		run_skip = 1'b0;

		case (mode_q)
			MODE_SKIP: begin
				run_skip = 1'b1;
			end
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					mode_d = MODE_LINE;
				end else if (c == CH_STAR) begin
					mode_d = MODE_BLOCK;
					star_d = 1'b0;
				end else begin
					nl_d = 1'b0;
					if (!is_blank(c)) begin
						// the slash already sits in entry 0
						wr_en   = 1'b1;
						wr_addr = IDX_W'(1);
						len_d   = LEN_W'(2);
						mode_d  = MODE_WORD;
					end else begin
						f_emit   = 1'b1;
						emit_len = LEN_W'(1);
						len_d    = '0;
						run_skip = 1'b1;
					end
				end
			end
			MODE_LINE: begin
				if (c == CH_NUL || c == CH_NL) begin
					run_skip = 1'b1;
				end
			end
			MODE_BLOCK: begin
				if (c == CH_NUL) begin
					star_d   = 1'b0;
					run_skip = 1'b1;
				end else if (star_q && c == CH_SLASH) begin
					mode_d = MODE_SKIP;
					star_d = 1'b0;
				end else begin
					if (c == CH_NL) begin
						line_d = line_inc;
					end
					star_d = (c == CH_STAR);
				end
			end
			MODE_QUOTE: begin
				if (c == CH_NL) begin
					line_d = line_inc;
				end
				if (c == CH_QUOTE || c == CH_NUL) begin
					f_emit   = 1'b1;
					emit_len = len_q;
					len_d    = '0;
					mode_d   = MODE_SKIP;
					run_skip = (c == CH_NUL);
				end else if (len_q < LEN_W'(TOKEN_MAX - 1)) begin
					wr_en = 1'b1;
					len_d = len_q + LEN_W'(1);
				end
			end
			MODE_WORD: begin
				if (!is_blank(c)) begin
					if (len_q < LEN_W'(TOKEN_MAX)) begin
						wr_en = 1'b1;
						len_d = len_q + LEN_W'(1);
					end
				end else begin
					// a word of TOKEN_MAX or more characters goes out as an empty token
					f_emit   = 1'b1;
					emit_len = (len_q >= LEN_W'(TOKEN_MAX)) ? '0 : len_q;
					len_d    = '0;
					run_skip = 1'b1;
				end
			end
			default: begin
				run_skip = 1'b1;
			end
		endcase

		nl_mid = nl_d;
		if (run_skip) begin
			mode_d = MODE_SKIP;
			if (c == CH_NUL) begin
				f_eof  = 1'b1;
				len_d  = '0;
				nl_d   = 1'b0;
				star_d = 1'b0;
			end else if (is_blank(c)) begin
				if (c == CH_NL) begin
					line_d = line_inc;
					nl_d   = 1'b1;
				end
			end else begin
				if (nl_mid && !allow_q) begin
					f_eol = 1'b1;
					nl_d  = 1'b0;
				end
				if (c == CH_SLASH) begin
					// park the slash in entry 0 in case it starts a word
					mode_d  = MODE_SLASH;
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = CH_SLASH;
				end else begin
					nl_d  = 1'b0;
					len_d = '0;
					if (c == CH_QUOTE) begin
						mode_d = MODE_QUOTE;
					end else begin
						wr_en   = 1'b1;
						wr_addr = '0;
						len_d   = LEN_W'(1);
						mode_d  = MODE_WORD;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP;
			len_q  <= '0;
			nl_q   <= 1'b0;
			star_q <= 1'b0;
			line_q <= '0;
		end else if (in_acc) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			nl_q   <= nl_d;
			star_q <= star_d;
			line_q <= line_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b1;
		end else if (cfg_wr_en) begin
			allow_q <= cfg_wr_data;
		end
	end

	cat_tok_ram #(
		.DEPTH  (TOKEN_MAX),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en && in_acc),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data_q)
	);

	assign out_load     = !out_valid_q || token.ready;
	assign tok_last_hit = (idx_q == emit_last_q);

	always_comb begin
		gen_valid = 1'b0;
		gen_kind  = KIND_CHAR;
		gen_char  = '0;
		gen_last  = 1'b1;
		case (state_q)
			ST_EOL: begin
				gen_valid = 1'b1;
				gen_kind  = KIND_EOL;
			end
			ST_TOK: begin
				gen_valid = 1'b1;
				gen_char  = rd_data_q;
				gen_last  = tok_last_hit;
			end
			ST_EMPTY: begin
				gen_valid = 1'b1;
				gen_kind  = KIND_EMPTY;
			end
			ST_EOF: begin
				gen_valid = 1'b1;
				gen_kind  = KIND_EOF;
			end
			default: begin
				gen_valid = 1'b0;
			end
		endcase
	end

	assign adv = gen_valid && out_load;

	always_comb begin
		state_d = state_q;
		rd_addr = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (f_eol) begin
						state_d = ST_EOL;
					end else if (f_emit && emit_len != '0) begin
						state_d = ST_PRIME;
					end else if (f_emit) begin
						state_d = ST_EMPTY;
					end else if (f_eof) begin
						state_d = ST_EOF;
					end
				end
			end
			ST_EOL: begin
				if (adv) begin
					state_d = ST_IDLE;
				end
			end
			ST_PRIME: begin
				rd_addr = '0;
				state_d = ST_TOK;
			end
			ST_TOK: begin
				if (adv) begin
					if (tok_last_hit) begin
						state_d = eof_q ? ST_EOF : ST_IDLE;
					end else begin
						// keep the ram one character ahead of the output
						rd_addr = idx_q + IDX_W'(1);
					end
				end
			end
			ST_EMPTY: begin
				if (adv) begin
					state_d = eof_q ? ST_EOF : ST_IDLE;
				end
			end
			ST_EOF: begin
				if (adv) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eof_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				eof_q <= f_eof;
			end
			if (out_load) begin
				out_valid_q <= gen_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= rd_addr;
		if (in_acc) begin
			emit_last_q <= IDX_W'(emit_len - LEN_W'(1));
			res_line_q  <= line_q;
		end
		if (adv) begin
			out_kind_q <= gen_kind;
			out_char_q <= gen_char;
			out_last_q <= gen_last;
			out_line_q <= res_line_q;
		end
	end

	assign token.valid       = out_valid_q;
	assign token.kind        = out_kind_q;
	assign token.tok_char    = out_char_q;
	assign token.tok_last    = out_last_q;
	assign token.line_number = out_line_q;

`ifndef SYNTH
	a_noncher_fields: assert property (@(posedge clk) disable iff (!arst_n)
		token.valid && token.kind != KIND_CHAR |-> token.tok_char == '0 && token.tok_last)
		else $error("non-character result with character fields set");

	a_idx_in_token: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TOK |-> idx_q <= emit_last_q)
		else $error("token read index beyond token end");

	a_line_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> line_q >= $past(line_q))
		else $error("line counter went backwards");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(TOKEN_MAX))
		else $error("token length beyond buffer depth");

	a_prime_then_tok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRIME |=> state_q == ST_TOK && idx_q == '0)
		else $error("token emission did not start at entry 0");
`endif

endmodule

// File: rtl/core/cat_tok_ram.sv
// token character buffer: one write port, one read port with registered data
// depends on cat_pkg for the character width
module cat_tok_ram #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic [cat_pkg::CHAR_W-1:0] wr_data,
	input  logic [ADDR_W-1:0]         rd_addr,
	output logic [cat_pkg::CHAR_W-1:0] rd_data
);
	import cat_pkg::*;

	logic [CHAR_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule
